// ----- sv/skwm_pkg.sv -----
// Shared types and constants of the kernel-weighted mean energy block.
`default_nettype none
package skwm_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   typedef struct packed {
      logic        used;
      logic        last;
      logic [63:0] r2;
      logic [63:0] h2;
      logic [31:0] mass;
      logic [31:0] energy;
   } entry_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SQUARE,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_SQRT,
      B_DIV,
      B_SQR,
      B_CUBE,
      B_WGT,
      B_MW,
      B_ME,
      B_ACC,
      B_FIN,
      B_QDIV,
      B_RES,
      B_EMIT
   } back_state_type;

endpackage
`default_nettype wire

// ----- sv/skwm_queue.sv -----
// Short queue of classified neighbour words between the front and back parts.
`default_nettype none
module skwm_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire skwm_pkg::entry_type push_entry,
   output logic                     push_ready,
   output logic                     pop_valid,
   output skwm_pkg::entry_type      pop_entry,
   input  wire logic                pop_ready
);

   skwm_pkg::entry_type                 mem_ff [skwm_pkg::QUEUE_DEPTH];
   logic [skwm_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [skwm_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [skwm_pkg::QUEUE_PTR_W:0]     count_ff, count_in;
   logic                               do_push, do_pop;

   assign push_ready = count_ff != (skwm_pkg::QUEUE_PTR_W+1)'(skwm_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ----- sv/skwm_front.sv -----
// Front part: takes neighbour words, forms the squared distance and classifies them.
`default_nettype none
module skwm_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic signed [31:0]  req_star_x,
   input  wire logic signed [31:0]  req_star_y,
   input  wire logic signed [31:0]  req_star_z,
   input  wire logic signed [31:0]  req_gas_x,
   input  wire logic signed [31:0]  req_gas_y,
   input  wire logic signed [31:0]  req_gas_z,
   input  wire logic [31:0]         req_gas_mass,
   input  wire logic [31:0]         req_gas_energy,
   input  wire logic [63:0]         req_radius_squared,
   input  wire logic                req_last_neighbour,
   output logic                     push_valid,
   output skwm_pkg::entry_type      push_entry,
   input  wire logic                push_ready
);

   skwm_pkg::front_state_type state_ff, state_in;
   logic [31:0] d0_ff, d1_ff, d2_ff;
   logic [63:0] r2_ff, h2_ff;
   logic        far_ff, last_ff;
   logic [31:0] mass_ff, energy_ff;
   logic [1:0]  cnt_ff;
   logic [31:0] ax, ay, az;
   logic [63:0] prod;
   logic [64:0] sum;
   logic        used;
   logic        accept;

   function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
      logic signed [32:0] d;
      d = 33'(a) - 33'(b);
      return d[32] ? 32'(-d) : d[31:0];
   endfunction

   assign accept = req_valid && req_ready;
   assign ax     = abs_diff(req_star_x, req_gas_x);
   assign ay     = abs_diff(req_star_y, req_gas_y);
   assign az     = abs_diff(req_star_z, req_gas_z);
   assign prod   = d0_ff * d0_ff;
   assign sum    = {1'b0, r2_ff} + {1'b0, prod};
   assign used   = !far_ff && (r2_ff < h2_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skwm_pkg::F_IDLE: begin
            if (accept) state_in = skwm_pkg::F_SQUARE;
         end
         skwm_pkg::F_SQUARE: begin
            if (cnt_ff == 2'd2) state_in = skwm_pkg::F_PUSH;
         end
         skwm_pkg::F_PUSH: begin
            if (!(used || last_ff) || push_ready) state_in = skwm_pkg::F_IDLE;
         end
         default: state_in = skwm_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      req_ready         = 1'b0;
      push_valid        = 1'b0;
      push_entry.used   = used;
      push_entry.last   = last_ff;
      push_entry.r2     = r2_ff;
      push_entry.h2     = h2_ff;
      push_entry.mass   = mass_ff;
      push_entry.energy = energy_ff;
      case (state_ff)
         skwm_pkg::F_IDLE: req_ready = 1'b1;
         skwm_pkg::F_PUSH: push_valid = used || last_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skwm_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         d0_ff     <= ax;
         d1_ff     <= ay;
         d2_ff     <= az;
         r2_ff     <= '0;
         far_ff    <= 1'b0;
         cnt_ff    <= '0;
         h2_ff     <= req_radius_squared;
         mass_ff   <= req_gas_mass;
         energy_ff <= req_gas_energy;
         last_ff   <= req_last_neighbour;
      end else if (state_ff == skwm_pkg::F_SQUARE) begin
         r2_ff  <= sum[63:0];
         far_ff <= far_ff | sum[64];
         d0_ff  <= d1_ff;
         d1_ff  <= d2_ff;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

endmodule
`default_nettype wire

// ----- sv/skwm_back.sv -----
// Back part: square roots, kernel weight, accumulation and the final ratio.
`default_nettype none
module skwm_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pop_valid,
   input  wire skwm_pkg::entry_type pop_entry,
   output logic                     pop_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [31:0]              rsp_mean_energy,
   output logic [1:0]               rsp_status
);

   skwm_pkg::back_state_type state_ff, state_in;
   skwm_pkg::entry_type      ent_ff;
   logic [63:0] rx_ff, rr_ff, hx_ff, hr_ff, bit_ff;
   logic [5:0]  cnt_ff;
   logic [48:0] rem_ff, den_ff;
   logic [16:0] q_ff, a_ff, w_ff;
   logic        lo_ff;
   logic [33:0] sq_ff;
   logic [50:0] cu_ff;
   logic [31:0] mw_ff;
   logic [63:0] me_ff;
   logic [63:0] msum_ff, esum_ff;
   logic        ovf_ff;
   logic [63:0] qrem_ff, quo_ff;
   logic [31:0] res_mean_ff;
   logic [1:0]  res_status_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_mean_ff;
   logic [1:0]  rsp_status_ff;

   logic [63:0] r_t, h_t, rx_n, rr_n, hx_n, hr_n;
   logic        div_ge;
   logic        lo;
   logic [16:0] a;
   logic [63:0] w48;
   logic [48:0] mw_prod;
   logic [64:0] msum_add, esum_add;
   logic [64:0] qsh;
   logic        q_ge;
   logic        emit_go;

   always_comb begin
      r_t  = rr_ff + bit_ff;
      h_t  = hr_ff + bit_ff;
      rx_n = rx_ff;
      rr_n = rr_ff >> 1;
      hx_n = hx_ff;
      hr_n = hr_ff >> 1;
      if (rx_ff >= r_t) begin
         rx_n = rx_ff - r_t;
         rr_n = (rr_ff >> 1) + bit_ff;
      end
      if (hx_ff >= h_t) begin
         hx_n = hx_ff - h_t;
         hr_n = (hr_ff >> 1) + bit_ff;
      end
   end

   assign div_ge   = rem_ff >= den_ff;
   assign lo       = q_ff < 17'd32768;
   assign a        = lo ? q_ff : 17'(18'd65536 - 18'(q_ff));
   assign mw_prod  = 49'(ent_ff.mass) * 49'(w_ff);
   assign msum_add = {1'b0, msum_ff} + 65'(mw_ff);
   assign esum_add = {1'b0, esum_ff} + {1'b0, me_ff};
   assign qsh      = {qrem_ff, quo_ff[63]};
   assign q_ge     = qsh >= {1'b0, msum_ff};
   assign emit_go  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (lo_ff) begin
         w48 = 64'h0001_0000_0000_0000 + 64'(cu_ff) * 64'd6
               - ((64'(sq_ff) * 64'd6) << 16);
      end else begin
         w48 = 64'(cu_ff) << 1;
      end
      w48 = w48 + 64'h0000_0000_8000_0000;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skwm_pkg::B_IDLE: begin
            if (pop_valid) begin
               if (pop_entry.used) state_in = skwm_pkg::B_SQRT;
               else if (pop_entry.last) state_in = skwm_pkg::B_FIN;
            end
         end
         skwm_pkg::B_SQRT: if (cnt_ff == 6'd31) state_in = skwm_pkg::B_DIV;
         skwm_pkg::B_DIV:  if (cnt_ff == 6'd16) state_in = skwm_pkg::B_SQR;
         skwm_pkg::B_SQR:  state_in = skwm_pkg::B_CUBE;
         skwm_pkg::B_CUBE: state_in = skwm_pkg::B_WGT;
         skwm_pkg::B_WGT:  state_in = skwm_pkg::B_MW;
         skwm_pkg::B_MW:   state_in = skwm_pkg::B_ME;
         skwm_pkg::B_ME:   state_in = skwm_pkg::B_ACC;
         skwm_pkg::B_ACC:  state_in = ent_ff.last ? skwm_pkg::B_FIN : skwm_pkg::B_IDLE;
         skwm_pkg::B_FIN:  state_in = (msum_ff == '0) ? skwm_pkg::B_EMIT : skwm_pkg::B_QDIV;
         skwm_pkg::B_QDIV: if (cnt_ff == 6'd63) state_in = skwm_pkg::B_RES;
         skwm_pkg::B_RES:  state_in = skwm_pkg::B_EMIT;
         skwm_pkg::B_EMIT: if (emit_go) state_in = skwm_pkg::B_IDLE;
         default:          state_in = skwm_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      pop_ready = 1'b0;
      case (state_ff)
         skwm_pkg::B_IDLE: pop_ready = 1'b1;
         default: ;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mean_energy = rsp_mean_ff;
   assign rsp_status      = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skwm_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
         msum_ff      <= '0;
         esum_ff      <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == skwm_pkg::B_EMIT && emit_go) begin
            rsp_valid_ff <= 1'b1;
            msum_ff      <= '0;
            esum_ff      <= '0;
            ovf_ff       <= 1'b0;
         end else begin
            if (rsp_ready) rsp_valid_ff <= 1'b0;
            if (state_ff == skwm_pkg::B_ACC) begin
               msum_ff <= msum_add[64] ? '1 : msum_add[63:0];
               esum_ff <= esum_add[64] ? '1 : esum_add[63:0];
               ovf_ff  <= ovf_ff | msum_add[64] | esum_add[64];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         skwm_pkg::B_IDLE: begin
            ent_ff <= pop_entry;
            rx_ff  <= pop_entry.r2;
            hx_ff  <= pop_entry.h2;
            rr_ff  <= '0;
            hr_ff  <= '0;
            bit_ff <= 64'h4000_0000_0000_0000;
            cnt_ff <= '0;
         end
         skwm_pkg::B_SQRT: begin
            rx_ff  <= rx_n;
            rr_ff  <= rr_n;
            hx_ff  <= hx_n;
            hr_ff  <= hr_n;
            bit_ff <= bit_ff >> 2;
            cnt_ff <= (cnt_ff == 6'd31) ? '0 : cnt_ff + 1'b1;
            rem_ff <= {1'b0, rr_n[31:0], 16'd0};
            den_ff <= {1'b0, hr_n[31:0], 16'd0};
            q_ff   <= '0;
         end
         skwm_pkg::B_DIV: begin
            if (div_ge) rem_ff <= rem_ff - den_ff;
            q_ff   <= {q_ff[15:0], div_ge};
            den_ff <= den_ff >> 1;
            cnt_ff <= cnt_ff + 1'b1;
         end
         skwm_pkg::B_SQR: begin
            a_ff  <= a;
            lo_ff <= lo;
            sq_ff <= 34'(a) * 34'(a);
         end
         skwm_pkg::B_CUBE: cu_ff <= 51'(sq_ff) * 51'(a_ff);
         skwm_pkg::B_WGT:  w_ff  <= w48[48:32];
         skwm_pkg::B_MW:   mw_ff <= mw_prod[47:16];
         skwm_pkg::B_ME:   me_ff <= 64'(mw_ff) * 64'(ent_ff.energy);
         skwm_pkg::B_FIN: begin
            qrem_ff       <= '0;
            quo_ff        <= esum_ff;
            cnt_ff        <= '0;
            res_mean_ff   <= '0;
            res_status_ff <= skwm_pkg::STATUS_ZERO;
         end
         skwm_pkg::B_QDIV: begin
            qrem_ff <= q_ge ? 64'(qsh - {1'b0, msum_ff}) : qsh[63:0];
            quo_ff  <= {quo_ff[62:0], q_ge};
            cnt_ff  <= cnt_ff + 1'b1;
         end
         skwm_pkg::B_RES: begin
            if (quo_ff[63:32] != '0) begin
               res_mean_ff   <= '1;
               res_status_ff <= skwm_pkg::STATUS_SAT;
            end else begin
               res_mean_ff   <= quo_ff[31:0];
               res_status_ff <= ovf_ff ? skwm_pkg::STATUS_SAT : skwm_pkg::STATUS_OK;
            end
         end
         skwm_pkg::B_EMIT: begin
            if (emit_go) begin
               rsp_mean_ff   <= res_mean_ff;
               rsp_status_ff <= res_status_ff;
            end
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/sph_kernel_weighted_mean_top.sv -----
// Top level of the kernel-weighted mean energy block.
// The front forms the squared distance and classifies each word, the queue passes it on,
// and the back runs 32 square-root steps and 17 divide steps for a used neighbour, plus
// the 64-step ratio divide on a last word.
// The back takes a new neighbour only once it is done with the last; the front can run
// ahead while the queue has room, and drops an unused neighbour that is not the last.
// Reset is synchronous and active high; it empties the queue and clears the sums.
`default_nettype none
module sph_kernel_weighted_mean_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_star_x,
   input  wire logic signed [31:0] req_star_y,
   input  wire logic signed [31:0] req_star_z,
   input  wire logic signed [31:0] req_gas_x,
   input  wire logic signed [31:0] req_gas_y,
   input  wire logic signed [31:0] req_gas_z,
   input  wire logic [31:0]        req_gas_mass,
   input  wire logic [31:0]        req_gas_energy,
   input  wire logic [63:0]        req_radius_squared,
   input  wire logic               req_last_neighbour,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [31:0]             rsp_mean_energy,
   output logic [1:0]              rsp_status
);

   logic                push_valid, push_ready;
   skwm_pkg::entry_type push_entry;
   logic                pop_valid, pop_ready;
   skwm_pkg::entry_type pop_entry;

   skwm_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_star_x         (req_star_x),
      .req_star_y         (req_star_y),
      .req_star_z         (req_star_z),
      .req_gas_x          (req_gas_x),
      .req_gas_y          (req_gas_y),
      .req_gas_z          (req_gas_z),
      .req_gas_mass       (req_gas_mass),
      .req_gas_energy     (req_gas_energy),
      .req_radius_squared (req_radius_squared),
      .req_last_neighbour (req_last_neighbour),
      .push_valid         (push_valid),
      .push_entry         (push_entry),
      .push_ready         (push_ready)
   );

   skwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   skwm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_entry       (pop_entry),
      .pop_ready       (pop_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mean_energy (rsp_mean_energy),
      .rsp_status      (rsp_status)
   );

   a_zero_status_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == skwm_pkg::STATUS_ZERO |-> rsp_mean_energy == '0)
      else $error("zero weight status with non-zero mean");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == skwm_pkg::STATUS_OK || rsp_status == skwm_pkg::STATUS_ZERO
                    || rsp_status == skwm_pkg::STATUS_SAT)
      else $error("undefined status code");

   a_unused_not_queued: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_entry.used || push_entry.last)
      else $error("unused non-final neighbour queued");

endmodule
`default_nettype wire

// ----- tb/sph_kernel_weighted_mean_checker.sv -----
// Checker that predicts the weighted mean energy results and compares them with the block.
`timescale 1ns / 100ps
module sph_kernel_weighted_mean_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic signed [31:0] req_star_x,
   input  wire logic signed [31:0] req_star_y,
   input  wire logic signed [31:0] req_star_z,
   input  wire logic signed [31:0] req_gas_x,
   input  wire logic signed [31:0] req_gas_y,
   input  wire logic signed [31:0] req_gas_z,
   input  wire logic [31:0]        req_gas_mass,
   input  wire logic [31:0]        req_gas_energy,
   input  wire logic [63:0]        req_radius_squared,
   input  wire logic               req_last_neighbour,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [31:0]        rsp_mean_energy,
   input  wire logic [1:0]         rsp_status,
   output int                      fail_count,
   output int                      pending_means
);

   typedef struct packed {
      logic [31:0] mean;
      logic [1:0]  status;
   } mean_result_type;

   mean_result_type mean_queue[$];
   logic [63:0]  mass_sum;
   logic [63:0]  energy_sum;
   logic         sum_saturated;

   assign pending_means = mean_queue.size();

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'h1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] spline(input logic [63:0] u);
      logic [63:0] w48;
      logic [63:0] t;
      if (u < 32768) begin
         w48 = (64'h1 << 48) + 6 * u * u * u - ((6 * u * u) << 16);
      end else begin
         t = 65536 - u;
         w48 = 2 * t * t * t;
      end
      return (w48 + (64'h1 << 31)) >> 32;
   endfunction

   task automatic add_sat(inout logic [63:0] acc, input logic [63:0] v);
      logic [64:0] s;
      s = {1'b0, acc} + {1'b0, v};
      if (s[64]) begin
         sum_saturated = 1'b1;
         acc = '1;
      end else begin
         acc = s[63:0];
      end
   endtask

   task automatic accumulate_neighbour();
      logic signed [32:0] dx, dy, dz;
      logic [65:0] r2w;
      logic [63:0] r, h, u, w, mw;
      mean_result_type res;
      logic [63:0] q;
      dx = $signed({req_star_x[31], req_star_x}) - $signed({req_gas_x[31], req_gas_x});
      dy = $signed({req_star_y[31], req_star_y}) - $signed({req_gas_y[31], req_gas_y});
      dz = $signed({req_star_z[31], req_star_z}) - $signed({req_gas_z[31], req_gas_z});
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dz < 0) dz = -dz;
      r2w = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy) + 66'(dz) * 66'(dz);
      if (r2w[65:64] == 0 && r2w[63:0] < req_radius_squared) begin
         r = int_sqrt(r2w[63:0]);
         h = int_sqrt(req_radius_squared);
         u = 65536;
         if (h != 0) begin
            u = (r << 16) / h;
            if (u > 65536) u = 65536;
         end
         w = spline(u);
         mw = (64'(req_gas_mass) * w) >> 16;
         add_sat(mass_sum, mw);
         add_sat(energy_sum, mw * 64'(req_gas_energy));
      end
      if (req_last_neighbour) begin
         if (mass_sum == 0) begin
            res.mean = 0;
            res.status = skwm_pkg::STATUS_ZERO;
         end else begin
            q = energy_sum / mass_sum;
            res.status = sum_saturated ? skwm_pkg::STATUS_SAT : skwm_pkg::STATUS_OK;
            if (q > 64'hFFFF_FFFF) begin
               q = 64'hFFFF_FFFF;
               res.status = skwm_pkg::STATUS_SAT;
            end
            res.mean = q[31:0];
         end
         mean_queue.push_back(res);
         mass_sum = 0;
         energy_sum = 0;
         sum_saturated = 0;
      end
   endtask

   always @(posedge clock) begin
      mean_result_type want;
      if (reset) begin
         mean_queue.delete();
         mass_sum = 0;
         energy_sum = 0;
         sum_saturated = 0;
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (mean_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result word: mean %h status %0d",
                           rsp_mean_energy, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               want = mean_queue.pop_front();
               if (want.mean !== rsp_mean_energy || want.status !== rsp_status) begin
                  if (fail_count < 10)
                     $display("mismatch: expected mean %h status %0d, got mean %h status %0d",
                              want.mean, want.status, rsp_mean_energy, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) accumulate_neighbour();
      end
   end
endmodule

// ----- tb/sph_kernel_weighted_mean_top_tb.sv -----
// Testbench top that drives neighbour words into the block and reports the verdict.
`timescale 1ns / 100ps
module sph_kernel_weighted_mean_top_tb;

   localparam int CYCLE_LIMIT = 2_000_000;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic signed [31:0] req_star_x = 0, req_star_y = 0, req_star_z = 0;
   logic signed [31:0] req_gas_x = 0, req_gas_y = 0, req_gas_z = 0;
   logic [31:0]        req_gas_mass = 0, req_gas_energy = 0;
   logic [63:0]        req_radius_squared = 0;
   logic               req_last_neighbour = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [31:0]        rsp_mean_energy;
   logic [1:0]         rsp_status;
   int                 fail_count;
   int                 pending_means;
   int                 cycle_count = 0;
   int                 send_idle_pct = 0;
   int                 stall_pct = 0;
   int                 hold_off = 0;
   logic               hold_req = 0;
   logic               hold_taken = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   sph_kernel_weighted_mean_top u_top (.*);

   sph_kernel_weighted_mean_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sph_kernel_weighted_mean_top_tb failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken <= 1;
         hold_off <= 3000;
         rsp_ready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(3))
         0: return $urandom();
         1: return {{16{1'b0}}, 16'($urandom())} ^ ({32{1'($urandom_range(1))}});
         default: return 32'($urandom_range(8 << 16)) - (4 << 16);
      endcase
   endfunction

   task automatic send(input logic [31:0] sx, sy, sz, gx, gy, gz, m, e,
                       input logic [63:0] h2, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_star_x <= sx;
      req_star_y <= sy;
      req_star_z <= sz;
      req_gas_x <= gx;
      req_gas_y <= gy;
      req_gas_z <= gz;
      req_gas_mass <= m;
      req_gas_energy <= e;
      req_radius_squared <= h2;
      req_last_neighbour <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random_star();
      logic [31:0] sx, sy, sz;
      logic [63:0] h2;
      int n;
      sx = pick_coord();
      sy = pick_coord();
      sz = pick_coord();
      case ($urandom_range(4))
         0: h2 = {$urandom(), $urandom()};
         1: h2 = '1;
         default: h2 = 64'($urandom_range(16)) << 32;
      endcase
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(4) == 0)
            send(sx, sy, sz, pick_coord(), pick_coord(), pick_coord(),
                 $urandom(), $urandom(), h2, k == n - 1);
         else
            send(sx, sy, sz, sx + 32'($urandom_range(1 << 17)) - (1 << 16),
                 sy + 32'($urandom_range(1 << 17)) - (1 << 16),
                 sz + 32'($urandom_range(1 << 17)) - (1 << 16),
                 ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(1 << 18)),
                 ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(1 << 20)),
                 h2, k == n - 1);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_means != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0002_0000, 64'h1_0000_0000, 1);
      send(0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 64'h1_0000_0000, 1);
      send(0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 1);
      send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
           32'h8000_0000, '1, '1, '1, 1);
      send(0, 0, 0, 32'h0000_8000, 0, 0, '1, '1, 64'h1_0000_0000, 0);
      send(0, 0, 0, 32'h0000_C000, 0, 0, '1, '1, 64'h1_0000_0000, 0);
      send(0, 0, 0, 32'h0000_FFFF, 0, 0, '1, '1, 64'h1_0000_0000, 1);
      send(0, 0, 0, 0, 0, 0, '1, '1, '1, 0);
      for (int k = 0; k < 8; k++)
         send(5, 5, 5, 5, 5, 5, '1, '1, '1, 0);
      send(5, 5, 5, 5, 5, 5, '1, '1, '1, 1);
      send(0, 0, 0, 0, 0, 0, 32'h0000_0001, '1, 64'h1_0000_0000, 1);
      send(0, 0, 0, 0, 0, 0, 32'h0000_0010, 32'h0000_0001, 1, 0);
      send(0, 0, 0, 0, 0, 0, 32'h0000_0010, 32'h0000_0001, 1, 1);
      send(0, 0, 0, 0, 0, 2, 32'h1_0000, 32'h1_0000, 1, 1);
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 29 : 88) : 0;
         stall_pct = (phase == 2) ? 88 : ((phase == 3) ? 29 : 0);
         if (phase == 0) hold_req <= 1;
         for (int s = 0; s < 40; s++) send_random_star();
         drain();
      end
      if (fail_count == 0)
         $display("sph_kernel_weighted_mean_top_tb passed");
      else
         $display("sph_kernel_weighted_mean_top_tb failed");
      $finish;
   end
endmodule
